[sv/i4p_pkg.sv]
// i4p_pkg: shared types, mode codes and sample arithmetic for the intra 4x4 predictor.
// No dependencies; imported by every module of the block.
package i4p_pkg;

    // Prediction mode codes; any code above horizontal-up predicts as horizontal-up
    localparam logic [3:0] MODE_VERT      = 4'd0;
    localparam logic [3:0] MODE_HORIZ     = 4'd1;
    localparam logic [3:0] MODE_DC        = 4'd2;
    localparam logic [3:0] MODE_DIAG_DL   = 4'd3;
    localparam logic [3:0] MODE_DIAG_DR   = 4'd4;
    localparam logic [3:0] MODE_VERT_R    = 4'd5;
    localparam logic [3:0] MODE_HORIZ_D   = 4'd6;
    localparam logic [3:0] MODE_VERT_L    = 4'd7;
    localparam logic [3:0] MODE_HORIZ_U   = 4'd8;

    // Availability flag bit positions
    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_TOP   = 1;
    localparam int FLAG_TR    = 2;

    localparam logic [7:0] DC_NONE_VALUE = 8'd128;
    localparam logic [1:0] LAST_ROW_IDX  = 2'd3;

    // Unified edge line: [0..3] = left 3..0, [4] = corner, [5..8] = top 0..3,
    // [9..12] = top-right 0..3 (or top 3 replicated)
    typedef logic [12:0][7:0] t_edge;
    // Two-tap averages of neighbors k, k+1 and three-tap of k, k+1, k+2
    typedef logic [11:0][7:0] t_f2;
    typedef logic [10:0][7:0] t_f3;

    // Row request leaving the issue stage
    typedef struct packed {
        logic [3:0] mode;
        logic [2:0] avail;
        logic [1:0] row;
        t_edge      edge_line;
    } t_edge_word;

    // Filtered neighbors for one row request
    typedef struct packed {
        logic [3:0] mode;
        logic [1:0] row;
        t_edge      edge_line;
        t_f2        f2;
        t_f3        f3;
        logic [7:0] sp3;   // (T6 + 3*T7 + 2) >> 2
        logic [7:0] sp8;   // (L2 + 3*L3 + 2) >> 2
        logic [7:0] dc;
    } t_filt_word;

    function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + 9'd1;
        return s[8:1];
    endfunction

    function automatic logic [7:0] avg3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [9:0] s;
        s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + 10'd2;
        return s[9:2];
    endfunction

    // One predicted sample at column x of row y, picked from the filtered edge
    function automatic logic [7:0] pick_sample(input t_filt_word w, input logic [1:0] x);
        int         xi;
        int         yi;
        int         z;
        int         i;
        logic [7:0] v;
        xi = int'(x);
        yi = int'(w.row);
        v  = '0;
        unique case (w.mode)
            MODE_VERT:  v = w.edge_line[4'(5 + xi)];
            MODE_HORIZ: v = w.edge_line[4'(3 - yi)];
            MODE_DC:    v = w.dc;
            MODE_DIAG_DL: begin
                if (xi == 3 && yi == 3) v = w.sp3;
                else                    v = w.f3[4'(5 + xi + yi)];
            end
            MODE_DIAG_DR: v = w.f3[4'(3 + xi - yi)];
            MODE_VERT_R: begin
                z = 2 * xi - yi;
                i = xi - (yi >> 1);
                if (z >= 0 && (z % 2) == 0) v = w.f2[4'(4 + i)];
                else if (z >= 0)            v = w.f3[4'(3 + i)];
                else if (z == -1)           v = w.f3[3];
                else                        v = w.f3[4'(4 - yi)];
            end
            MODE_HORIZ_D: begin
                z = 2 * yi - xi;
                i = yi - (xi >> 1);
                if (z >= 0 && (z % 2) == 0) v = w.f2[4'(3 - i)];
                else if (z >= 0)            v = w.f3[4'(3 - i)];
                else if (z == -1)           v = w.f3[3];
                else                        v = w.f3[4'(2 + xi)];
            end
            MODE_VERT_L: begin
                i = xi + (yi >> 1);
                if (yi % 2 == 1) v = w.f3[4'(5 + i)];
                else             v = w.f2[4'(5 + i)];
            end
            default: begin
                // horizontal-up
                z = xi + 2 * yi;
                i = yi + (xi >> 1);
                if (z > 5)           v = w.edge_line[0];
                else if (z == 5)     v = w.sp8;
                else if (z % 2 == 1) v = w.f3[4'(1 - i)];
                else                 v = w.f2[4'(2 - i)];
            end
        endcase
        return v;
    endfunction

endpackage

[sv/intra4x4_predictor.sv]
// intra4x4_predictor: top level of the 4x4 luma intra predictor.
// Depends on i4p_pkg, i4p_row_issue, i4p_filter and i4p_select.
//
// One accepted word is a 4x4 block request: mode, availability flags and the
// thirteen neighbor samples. The block returns four row words, top row first,
// each carrying four packed predicted samples, the row index and a last-row
// flag. The four rows leave one per cycle while the result channel is not stalled,
// on the single result channel, and a new block is taken in the cycle its
// predecessor issues its last row. Each row passes through the hold and issue
// stage, the filter and the select stage; both channels may stall freely
// without loss or repetition.
module intra4x4_predictor
    import i4p_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_mode,
    input  logic [2:0]  i_avail_flags,
    input  logic [7:0]  i_corner,
    input  logic [31:0] i_top_row,
    input  logic [31:0] i_top_right,
    input  logic [31:0] i_left_column,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_row_pixels,
    output logic [1:0]  o_row_index,
    output logic        o_last_row
);

    logic        edge_valid;
    t_edge_word  edge_word;
    logic        filt_ready;
    logic        filt_valid;
    t_filt_word  filt_word;
    logic        sel_ready;

    // block hold and row issue
    i4p_row_issue u_issue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_avail_flags (i_avail_flags),
        .i_corner      (i_corner),
        .i_top_row     (i_top_row),
        .i_top_right   (i_top_right),
        .i_left_column (i_left_column),
        .o_valid       (edge_valid),
        .o_word        (edge_word),
        .i_next_ready  (filt_ready)
    );

    // edge filtering and DC
    i4p_filter u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (edge_valid),
        .i_word       (edge_word),
        .o_ready      (filt_ready),
        .o_valid      (filt_valid),
        .o_word       (filt_word),
        .i_next_ready (sel_ready)
    );

    // mode selection and output register
    i4p_select u_select (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (filt_valid),
        .i_word       (filt_word),
        .o_ready      (sel_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_row_pixels (o_row_pixels),
        .o_row_index  (o_row_index),
        .o_last_row   (o_last_row)
    );

endmodule

[sv/i4p_row_issue.sv]
// i4p_row_issue: holds one accepted block and issues its four row requests in order.
// Depends on i4p_pkg (t_edge_word, flag positions).
module i4p_row_issue
    import i4p_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_mode,
    input  logic [2:0]  i_avail_flags,
    input  logic [7:0]  i_corner,
    input  logic [31:0] i_top_row,
    input  logic [31:0] i_top_right,
    input  logic [31:0] i_left_column,
    output logic        o_valid,
    output t_edge_word  o_word,
    input  logic        i_next_ready
);

    logic        r_hold_valid;
    logic [1:0]  r_row;
    logic [3:0]  r_mode;
    logic [2:0]  r_avail;
    t_edge       r_edge;
    logic        r_out_valid;
    t_edge_word  r_out;

    logic        out_ready;
    logic        issue;
    logic        accept;
    t_edge       in_edge;

    assign out_ready = !r_out_valid || i_next_ready;
    assign issue     = r_hold_valid && out_ready;
    // a new block may land as the last row of the held one goes out
    assign o_stall   = r_hold_valid && !(issue && r_row == LAST_ROW_IDX);
    assign accept    = i_valid && !o_stall;

    // edge line, with top-right replaced by top 3 when not available
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            in_edge[4'(3 - k)] = i_left_column[5'(8*k) +: 8];
            in_edge[4'(5 + k)] = i_top_row[5'(8*k) +: 8];
            in_edge[4'(9 + k)] = i_avail_flags[FLAG_TR] ? i_top_right[5'(8*k) +: 8]
                                                        : i_top_row[31:24];
        end
        in_edge[4] = i_corner;
    end

    // hold control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_row        <= '0;
        end else if (accept) begin
            r_hold_valid <= 1'b1;
            r_row        <= '0;
        end else if (issue) begin
            r_row <= r_row + 2'd1;
            if (r_row == LAST_ROW_IDX) r_hold_valid <= 1'b0;
        end
    end

    // hold payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_avail <= i_avail_flags;
            r_edge  <= in_edge;
        end
    end

    // row request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out.mode      <= r_mode;
            r_out.avail     <= r_avail;
            r_out.row       <= r_row;
            r_out.edge_line <= r_edge;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

[sv/i4p_filter.sv]
// i4p_filter: two- and three-tap averages along the edge line plus the DC value.
// Depends on i4p_pkg (word types, avg2/avg3).
module i4p_filter
    import i4p_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_edge_word  i_word,
    output logic        o_ready,
    output logic        o_valid,
    output t_filt_word  o_word,
    input  logic        i_next_ready
);

    logic        r_valid;
    t_filt_word  r_word;
    t_filt_word  n_word;
    logic [9:0]  sum_top;
    logic [9:0]  sum_left;
    logic [10:0] sum_both;
    logic [7:0]  dc_value;

    assign o_ready = !r_valid || i_next_ready;

    // filters over the edge line
    always_comb begin
        for (int k = 0; k < 12; k++) begin
            n_word.f2[4'(k)] = avg2(i_word.edge_line[4'(k)], i_word.edge_line[4'(k + 1)]);
        end
        for (int k = 0; k < 11; k++) begin
            n_word.f3[4'(k)] = avg3(i_word.edge_line[4'(k)], i_word.edge_line[4'(k + 1)],
                                    i_word.edge_line[4'(k + 2)]);
        end
        n_word.sp3       = avg3(i_word.edge_line[11], i_word.edge_line[12],
                                i_word.edge_line[12]);
        n_word.sp8       = avg3(i_word.edge_line[1], i_word.edge_line[0],
                                i_word.edge_line[0]);
        n_word.mode      = i_word.mode;
        n_word.row       = i_word.row;
        n_word.edge_line = i_word.edge_line;
        n_word.dc        = dc_value;
    end

    // DC with fallbacks by availability
    always_comb begin
        sum_top  = {2'b00, i_word.edge_line[5]} + {2'b00, i_word.edge_line[6]}
                 + {2'b00, i_word.edge_line[7]} + {2'b00, i_word.edge_line[8]};
        sum_left = {2'b00, i_word.edge_line[0]} + {2'b00, i_word.edge_line[1]}
                 + {2'b00, i_word.edge_line[2]} + {2'b00, i_word.edge_line[3]};
        sum_both = {1'b0, sum_top} + {1'b0, sum_left} + 11'd4;
        if (i_word.avail[FLAG_LEFT] && i_word.avail[FLAG_TOP]) begin
            dc_value = sum_both[10:3];
        end else if (i_word.avail[FLAG_LEFT]) begin
            dc_value = 8'((sum_left + 10'd2) >> 2);
        end else if (i_word.avail[FLAG_TOP]) begin
            dc_value = 8'((sum_top + 10'd2) >> 2);
        end else begin
            dc_value = DC_NONE_VALUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

[sv/i4p_select.sv]
// i4p_select: per-column mode selection and the result row register.
// Depends on i4p_pkg (t_filt_word, pick_sample).
module i4p_select
    import i4p_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_filt_word  i_word,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_row_pixels,
    output logic [1:0]  o_row_index,
    output logic        o_last_row
);

    logic        r_valid;
    logic [31:0] r_pixels;
    logic [1:0]  r_row;
    logic [31:0] n_pixels;

    assign o_ready = !r_valid || !i_stall;

    // four sample lanes, one per column
    always_comb begin
        for (int x = 0; x < 4; x++) begin
            n_pixels[5'(8*x) +: 8] = pick_sample(i_word, 2'(x));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pixels <= n_pixels;
            r_row    <= i_word.row;
        end
    end

    assign o_valid      = r_valid;
    assign o_row_pixels = r_pixels;
    assign o_row_index  = r_row;
    assign o_last_row   = (r_row == LAST_ROW_IDX);

endmodule
